FILE: sv/deq_pkg.sv
`timescale 1ns / 1ps
// Package with the sizes, operation codes and status codes of the double-ended queue.
package deq_pkg;

  localparam int DEPTH  = 1024;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_PUSH_DONE  = 2'd0;
  localparam logic [1:0] ST_POP_DONE   = 2'd1;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd2;
  localparam logic [1:0] ST_PUSH_FULL  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // take the input word and perform its access
    logic load_out;  // move the finished result into the output register
  } deq_cmd_t;

endpackage

FILE: sv/deq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input and result words of the queue.
interface deq_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic signed [deq_pkg::DATA_W-1:0]   push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface deq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [deq_pkg::DATA_W-1:0]   pop_value;
  logic [1:0]                          status;
  logic [deq_pkg::CNT_W-1:0]           occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  output ready);
endinterface

FILE: sv/double_ended_queue_unit.sv
`timescale 1ns / 1ps
// Top level of the double-ended queue: controller and datapath joined by commands.
//
//   channel   dir   handshake       payload
//   in_ch     in    valid / ready   func, push_value
//   out_ch    out   valid / ready   pop_value, status, occupancy
//
// Each word passes through two steps: the indices are updated and the single-port ring
// memory is accessed, then the registered read data moves into the output register.
// A new word is accepted while a finished result still waits in the output register;
// a stalled output holds the second word in the access stage until the register frees.
// Reset clears the indices and the count; the memory itself is not cleared.
module double_ended_queue_unit (
  input  logic       clk,
  input  logic       rst_n,
  deq_in_if.sink     in_ch,
  deq_out_if.source  out_ch
);

  deq_pkg::deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  deq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .func       (in_ch.func),
    .push_value (in_ch.push_value),
    .pop_value  (out_ch.pop_value),
    .status     (out_ch.status),
    .occupancy  (out_ch.occupancy)
  );

endmodule

FILE: sv/deq_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences the memory access and the output register.
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output deq_pkg::deq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_ACCESS = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready     = (state_r == S_IDLE);
  assign cmd.accept   = in_ready && in_valid;
  // The result enters the output register once the previous word has left or is leaving.
  assign cmd.load_out = (state_r == S_ACCESS) && (!out_valid_r || out_ready);
  assign out_valid    = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_ACCESS;
      end
      S_ACCESS: begin
        if (cmd.load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/deq_dp.sv
`timescale 1ns / 1ps
// Datapath: ring memory, front and back indices, entry count and output register.
module deq_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  deq_pkg::deq_cmd_t                 cmd,
  input  logic [1:0]                        func,
  input  logic signed [deq_pkg::DATA_W-1:0] push_value,
  output logic signed [deq_pkg::DATA_W-1:0] pop_value,
  output logic [1:0]                        status,
  output logic [deq_pkg::CNT_W-1:0]         occupancy
);

  logic [deq_pkg::DATA_W-1:0] mem [deq_pkg::DEPTH];

  logic [deq_pkg::IDX_W-1:0]  front_r, front_nxt;
  logic [deq_pkg::IDX_W-1:0]  back_r, back_nxt;
  logic [deq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [1:0]                 status_r, status_nxt;
  logic [deq_pkg::DATA_W-1:0] rd_r;

  logic                       mem_we, mem_re;
  logic [deq_pkg::IDX_W-1:0]  mem_addr;
  logic                       full, empty;

  logic signed [deq_pkg::DATA_W-1:0] out_pop_value_r;
  logic [1:0]                        out_status_r;
  logic [deq_pkg::CNT_W-1:0]         out_occ_r;

  function automatic logic [deq_pkg::IDX_W-1:0] ring_next(
    input logic [deq_pkg::IDX_W-1:0] idx);
    return (idx == deq_pkg::IDX_W'(deq_pkg::DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [deq_pkg::IDX_W-1:0] ring_prev(
    input logic [deq_pkg::IDX_W-1:0] idx);
    return (idx == '0) ? deq_pkg::IDX_W'(deq_pkg::DEPTH - 1) : idx - 1'b1;
  endfunction

  assign full  = (count_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = front_r;
    if (cmd.accept) begin
      unique case (func)
        deq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status_nxt = deq_pkg::ST_PUSH_FULL;
          end else begin
            front_nxt  = ring_prev(front_r);
            mem_addr   = front_nxt;
            mem_we     = 1'b1;
            count_nxt  = count_r + 1'b1;
            status_nxt = deq_pkg::ST_PUSH_DONE;
          end
        end
        deq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_nxt = deq_pkg::ST_PUSH_FULL;
          end else begin
            mem_addr   = back_r;
            mem_we     = 1'b1;
            back_nxt   = ring_next(back_r);
            count_nxt  = count_r + 1'b1;
            status_nxt = deq_pkg::ST_PUSH_DONE;
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status_nxt = deq_pkg::ST_POP_EMPTY;
          end else begin
            mem_addr   = front_r;
            mem_re     = 1'b1;
            front_nxt  = ring_next(front_r);
            count_nxt  = count_r - 1'b1;
            status_nxt = deq_pkg::ST_POP_DONE;
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status_nxt = deq_pkg::ST_POP_EMPTY;
          end else begin
            back_nxt   = ring_prev(back_r);
            mem_addr   = back_nxt;
            mem_re     = 1'b1;
            count_nxt  = count_r - 1'b1;
            status_nxt = deq_pkg::ST_POP_DONE;
          end
        end
        default: status_nxt = status_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= push_value;
    if (mem_re) rd_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (cmd.load_out) begin
      out_pop_value_r <= (status_r == deq_pkg::ST_POP_DONE) ? rd_r : '0;
      out_status_r    <= status_r;
      out_occ_r       <= count_r;
    end
  end

  assign pop_value = out_pop_value_r;
  assign status    = out_status_r;
  assign occupancy = out_occ_r;

endmodule

FILE: sv/deq_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the double-ended queue, bound to the top level.
module deq_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [deq_pkg::DATA_W-1:0]  pop_value,
  input logic [1:0]                  status,
  input logic [deq_pkg::CNT_W-1:0]   occupancy
);

  // A full queue is the only reason a push is refused.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == deq_pkg::ST_PUSH_FULL |->
      occupancy == deq_pkg::CNT_W'(deq_pkg::DEPTH) && pop_value == '0)
    else $error("push refused while queue not full");

  // A pop is refused only on an empty queue.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == deq_pkg::ST_POP_EMPTY |-> occupancy == '0 && pop_value == '0)
    else $error("pop refused while queue not empty");

  // A successful push leaves at least one entry and returns no value.
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == deq_pkg::ST_PUSH_DONE |-> occupancy != '0 && pop_value == '0)
    else $error("push result inconsistent");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occupancy <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("occupancy beyond queue depth");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pop_value) && $stable(status)
      && $stable(occupancy))
    else $error("stalled result word changed");

endmodule

bind double_ended_queue_unit deq_chk u_deq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pop_value (out_ch.pop_value),
  .status    (out_ch.status),
  .occupancy (out_ch.occupancy)
);
